[rtl/bda_pkg.sv]
package bda_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    typedef logic [CHAR_W-1:0] t_char;

    typedef struct packed {
        logic                 done;
        logic [BCD_W-1:0]     bcd;
        logic [DIG_CNT_W-1:0] ndig;
    } t_dab_res;

endpackage

[rtl/bda_dabble.sv]
module bda_dabble (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bda_pkg::VALUE_WIDTH-1:0]   i_mag,
    output bda_pkg::t_dab_res                 o_res
);
    import bda_pkg::*;

    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [DIG_CNT_W-1:0]   r_ndig, n_ndig;
    logic [BIT_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   r_run, n_run;
    logic                   r_done, n_done;

    logic [BCD_W-1:0]       adj;
    logic [BCD_W-1:0]       shifted;
    logic [DIG_IDX_W-1:0]   top_idx;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
        shifted = {adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
        top_idx = r_ndig[DIG_IDX_W-1:0];

        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_ndig = r_ndig;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;

        if (i_start) begin
            n_bin  = i_mag;
            n_bcd  = '0;
            n_ndig = '0;
            n_cnt  = BIT_CNT_W'(VALUE_WIDTH - 1);
            n_run  = 1'b1;
        end else if (r_run) begin
            n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
            n_bcd = shifted;
            if ((r_ndig < DIG_CNT_W'(NUM_DIGITS)) && (shifted[4*top_idx +: 4] != 4'd0)) begin
                n_ndig = r_ndig + 1'b1;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_ndig <= n_ndig;
        r_cnt  <= n_cnt;
    end

    assign o_res.done = r_done;
    assign o_res.bcd  = r_bcd;
    assign o_res.ndig = r_ndig;

endmodule

[rtl/bda_emit.sv]
module bda_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bda_pkg::t_dab_res    i_res,
    input  logic                 i_neg,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output bda_pkg::t_char       m_axis_tdata,
    output logic                 m_axis_tlast
);
    import bda_pkg::*;

    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [DIG_IDX_W-1:0] r_idx, n_idx;
    logic                 r_active, n_active;
    logic                 r_sign, n_sign;
    logic                 r_tvalid, n_tvalid;
    t_char                r_tdata, n_tdata;
    logic                 r_tlast, n_tlast;

    logic [DIG_CNT_W-1:0] top;
    logic [3:0]           digit;

    always_comb begin
        top   = i_res.ndig - 1'b1;
        digit = r_bcd[4*r_idx +: 4];

        n_bcd    = r_bcd;
        n_idx    = r_idx;
        n_active = r_active;
        n_sign   = r_sign;
        n_tvalid = r_tvalid;
        n_tdata  = r_tdata;
        n_tlast  = r_tlast;

        if (r_tvalid && m_axis_tready) begin
            n_tvalid = 1'b0;
        end

        if (i_res.done) begin
            n_bcd    = i_res.bcd;
            n_active = 1'b1;
            n_sign   = i_neg;
            if (i_res.ndig == '0) begin
                n_idx = '0;
            end else begin
                n_idx = top[DIG_IDX_W-1:0];
            end
        end else if (r_active && (!r_tvalid || m_axis_tready)) begin
            n_tvalid = 1'b1;
            if (r_sign) begin
                n_tdata = ASCII_MINUS;
                n_tlast = 1'b0;
                n_sign  = 1'b0;
            end else begin
                n_tdata = ASCII_ZERO + {4'd0, digit};
                n_tlast = (r_idx == '0);
                if (r_idx == '0) begin
                    n_active = 1'b0;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_sign   <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_sign   <= n_sign;
            r_tvalid <= n_tvalid;
        end
        r_bcd   <= n_bcd;
        r_idx   <= n_idx;
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

endmodule

[rtl/binary_to_decimal_ascii.sv]
// Channel   Dir  tdata (low bit up)        tuser / tlast
// s_axis    in   value[63:0]                tuser: func (1 = signed)
// m_axis    out  character[7:0]             tlast: last_char
//
// One beat in at a time; s_axis_tready is high only while idle.
// Conversion runs in the bit-serial shift-add-3 register, then one
// character per cycle leaves the output register while m_axis_tready
// is high: up to 20 beats. Between one accepted beat and the next, the
// block shifts the value, loads the output, sends n characters, goes idle.
// Reset is synchronous, active low; m_axis stalls hold the output beat.
module binary_to_decimal_ascii (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bda_pkg::VALUE_WIDTH-1:0]   s_axis_tdata,  // value
    input  logic                              s_axis_tuser,  // func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bda_pkg::CHAR_W-1:0]        m_axis_tdata,  // character
    output logic                              m_axis_tlast
);
    import bda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_neg, n_neg;
    logic                   accept;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag;
    t_dab_res               dab_res;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign neg_in = s_axis_tuser && s_axis_tdata[VALUE_WIDTH-1];
    assign mag    = neg_in ? (~s_axis_tdata + 1'b1) : s_axis_tdata;

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CONV;
                    n_neg   = neg_in;
                end
            end
            S_CONV: begin
                if (dab_res.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg <= n_neg;
    end

    assign s_axis_tready = (r_state == S_IDLE);

    bda_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_mag   (mag),
        .o_res   (dab_res)
    );

    bda_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res         (dab_res),
        .i_neg         (r_neg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[rtl/bda_checker.sv]
module bda_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [bda_pkg::CHAR_W-1:0]        m_axis_tdata,
    input  logic                              m_axis_tlast
);
    import bda_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a number is in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("ready for input while characters remain");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after final character");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata == ASCII_MINUS) ||
            ((m_axis_tdata >= ASCII_ZERO) && (m_axis_tdata <= ASCII_ZERO + 8'd9))))
        else $error("character outside digit and minus set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
        else $error("stalled output beat changed");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
